// ----- rtl/core/assert_macros.svh -----
// Assertion helper macros for the bit tree block.
// Included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define CHK_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, ante, cons)
`define CHK_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- rtl/core/btps_pkg.sv -----
// Shared types and constants for the bit tree predecessor/successor block.
// No dependencies.
package btps_pkg;
    localparam int LEAVES_DEF     = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int OP_W           = 3;
    localparam int KEY_W          = 10;
    localparam int IN_VALUE_W     = 32;
    localparam int COUNT_MAX      = 1023;

    localparam logic [OP_W-1:0] OP_INS_PRUNE = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE    = 3'd2;
    localparam logic [OP_W-1:0] OP_PRED      = 3'd3;
    localparam logic [OP_W-1:0] OP_SUCC      = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]              operation;
        logic [KEY_W-1:0]             key;
        logic signed [IN_VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic                         found;
        logic [KEY_W-1:0]             found_key;
        logic signed [IN_VALUE_W-1:0] found_value;
        logic [KEY_W-1:0]             removed_count;
    } out_item_t;
endpackage

// ----- rtl/core/btps_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module btps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/core/btps_front.sv -----
// Front end: accepts items, classifies them, and queues them for the engine.
// Depends on btps_pkg and assert_macros.svh.
`include "assert_macros.svh"
module btps_front #(
    parameter int LEAVES = btps_pkg::LEAVES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  btps_pkg::in_item_t in_item,
    output logic              q_valid,
    input  logic              q_take,
    output btps_pkg::in_item_t q_item,
    output logic              q_noop
);
    localparam int DEPTH = 2;

    btps_pkg::in_item_t slot_reg [DEPTH];
    logic               noop_reg [DEPTH];
    logic               wp_reg, rp_reg;
    logic [1:0]         cnt_reg;
    logic               do_push, do_pop, noop_in;

    // Unknown codes and out of range keys produce an all-zero result.
    always_comb
    begin
        noop_in = (in_item.operation > btps_pkg::OP_SUCC)
            || ({22'd0, in_item.key} >= 32'(LEAVES));
    end

    assign full    = (cnt_reg == 2'(DEPTH));
    assign do_push = push && !full;
    assign q_valid = (cnt_reg != 2'd0);
    assign do_pop  = q_take && q_valid;
    assign q_item  = slot_reg[rp_reg];
    assign q_noop  = noop_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg] <= in_item;
            noop_reg[wp_reg] <= noop_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push) wp_reg <= ~wp_reg;
            if (do_pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    `CHK_NEVER(a_cnt_range, clk, rst_n, cnt_reg > 2'(DEPTH))
    `CHK_IMPL(a_ptr_eq, clk, rst_n, cnt_reg == 2'd0 || cnt_reg == 2'(DEPTH), wp_reg == rp_reg)
    `CHK_IMPL(a_ptr_ne, clk, rst_n, cnt_reg == 2'd1, wp_reg != rp_reg)
endmodule

// ----- rtl/core/btps_engine.sv -----
// Back end: walks the occupancy tree node by node (node bit read, then move) and drives results.
// Depends on btps_pkg, btps_ram and assert_macros.svh.
`include "assert_macros.svh"
module btps_engine #(
    parameter int LEAVES     = btps_pkg::LEAVES_DEF,
    parameter int VALUE_BITS = btps_pkg::VALUE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_take,
    input  btps_pkg::in_item_t q_item,
    input  logic               q_noop,
    output logic               empty,
    input  logic               pop,
    output btps_pkg::out_item_t out_item
);
    localparam int LB  = $clog2(LEAVES);
    localparam int NW  = LB + 1;
    localparam int CW  = $clog2(btps_pkg::COUNT_MAX + 1);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_CLEAR   = 11'b00000000010,
        S_ADD     = 11'b00000000100,
        S_REM     = 11'b00000001000,
        S_UP      = 11'b00000010000,
        S_DOWN    = 11'b00000100000,
        S_VREAD   = 11'b00001000000,
        S_VWAIT   = 11'b00010000000,
        S_VCMP    = 11'b00100000000,
        S_OUT     = 11'b01000000000,
        S_KREAD   = 11'b10000000000
    } state_t;

    state_t                 state_reg;
    logic [NW-1:0]          node_reg;
    logic [LB-1:0]          key_reg;
    logic [btps_pkg::OP_W-1:0] op_reg;
    logic [VALUE_BITS-1:0]  newv_reg;
    logic [LB-1:0]          cand_reg;
    logic                   pred_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   oval_reg;
    btps_pkg::out_item_t    obuf_reg;
    logic                   rd_ok_reg;
    logic [LB-1:0]          clr_reg;

    logic [LB-1:0]          par;
    logic                   is_right, pl, pr, nl, nr, inner;
    logic                   ram_we;
    logic [LB-1:0]          ram_ra;
    logic [VALUE_BITS-1:0]  ram_rd, in_v;
    logic                   l_rd, r_rd, l_we, r_we, bit_wd;
    logic [LB-1:0]          bit_ra, bit_wa;
    logic                   add_stop, rem_stop, tree_wr, clearing, q_hit;

    assign in_v   = VALUE_BITS'(q_item.value);
    assign par    = node_reg[NW-1:1];
    assign is_right = node_reg[0];
    assign inner  = !node_reg[NW-1];
    // node bits arrive in the cycle after the address: parent when adding or climbing, node when removing or descending
    assign bit_ra = (state_reg == S_ADD || state_reg == S_UP) ? par : node_reg[LB-1:0];
    assign pl     = l_rd;
    assign pr     = r_rd;
    assign nl     = inner && l_rd;
    assign nr     = inner && r_rd;
    assign add_stop = (par == '0) || (is_right ? pr : pl);
    assign rem_stop = (par == '0) || nl || nr;
    assign tree_wr  = rd_ok_reg && ((state_reg == S_ADD && !add_stop)
        || (state_reg == S_REM && !rem_stop));
    assign clearing = (state_reg == S_CLEAR);
    assign bit_wa = clearing ? clr_reg : par;
    assign bit_wd = (state_reg == S_ADD);
    assign l_we   = clearing || (tree_wr && !is_right);
    assign r_we   = clearing || (tree_wr && is_right);
    assign q_hit  = (op_reg == btps_pkg::OP_PRED || op_reg == btps_pkg::OP_SUCC)
        && node_reg != NW'(1);
    assign empty  = !oval_reg;
    assign out_item = obuf_reg;
    assign q_take = (state_reg == S_IDLE) && q_valid && !oval_reg;
    assign ram_we = q_take && !q_noop && (q_item.operation == btps_pkg::OP_INS_PRUNE
        || q_item.operation == btps_pkg::OP_INSERT);
    assign ram_ra = cand_reg;

    btps_ram #(.WIDTH(VALUE_BITS), .DEPTH(LEAVES)) u_vals (
        .clk(clk), .we(ram_we), .waddr(LB'(q_item.key)), .wdata(in_v),
        .raddr(ram_ra), .rdata(ram_rd)
    );

    btps_ram #(.WIDTH(1), .DEPTH(LEAVES)) u_lbits (
        .clk(clk), .we(l_we), .waddr(bit_wa), .wdata(bit_wd),
        .raddr(bit_ra), .rdata(l_rd)
    );

    btps_ram #(.WIDTH(1), .DEPTH(LEAVES)) u_rbits (
        .clk(clk), .we(r_we), .waddr(bit_wa), .wdata(bit_wd),
        .raddr(bit_ra), .rdata(r_rd)
    );

    function automatic logic [btps_pkg::IN_VALUE_W-1:0] widen(input logic [VALUE_BITS-1:0] v);
        return btps_pkg::IN_VALUE_W'(signed'({{64{v[VALUE_BITS-1]}}, v}));
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            rd_ok_reg <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            if (pop && oval_reg) oval_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    // zero every node word once after reset
                    clr_reg <= clr_reg + LB'(1);
                    if (clr_reg == LB'(LEAVES - 1)) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_take)
                    begin
                        op_reg   <= q_item.operation;
                        key_reg  <= LB'(q_item.key);
                        newv_reg <= in_v;
                        node_reg <= {1'b1, LB'(q_item.key)};
                        cnt_reg  <= '0;
                        pred_reg <= (q_item.operation == btps_pkg::OP_PRED);
                        if (q_noop)
                        begin
                            obuf_reg  <= '0;
                            oval_reg  <= 1'b1;
                        end
                        else
                        begin
                            case (q_item.operation)
                                btps_pkg::OP_INS_PRUNE, btps_pkg::OP_INSERT:
                                    state_reg <= S_ADD;
                                btps_pkg::OP_DELETE: state_reg <= S_REM;
                                default: state_reg <= S_UP;
                            endcase
                        end
                    end
                end
                S_ADD:
                begin
                    if (!rd_ok_reg)
                        rd_ok_reg <= 1'b1;
                    else
                    begin
                        rd_ok_reg <= 1'b0;
                        if (add_stop)
                        begin
                            if (op_reg == btps_pkg::OP_INS_PRUNE)
                            begin
                                node_reg  <= {1'b1, key_reg};
                                state_reg <= S_UP;
                            end
                            else
                                state_reg <= S_OUT;
                        end
                        else
                            node_reg <= {1'b0, node_reg[NW-1:1]};
                    end
                end
                S_REM:
                begin
                    if (!rd_ok_reg)
                        rd_ok_reg <= 1'b1;
                    else
                    begin
                        rd_ok_reg <= 1'b0;
                        if (rem_stop)
                        begin
                            if (op_reg == btps_pkg::OP_INS_PRUNE)
                            begin
                                node_reg  <= {1'b1, key_reg};
                                state_reg <= S_UP;
                            end
                            else
                                state_reg <= S_OUT;
                        end
                        else
                            node_reg <= {1'b0, node_reg[NW-1:1]};
                    end
                end
                S_UP:
                begin
                    // climb until a sibling subtree on the wanted side holds a key, or the root is reached
                    if (!rd_ok_reg)
                        rd_ok_reg <= 1'b1;
                    else
                    begin
                        rd_ok_reg <= 1'b0;
                        if (par == '0)
                            state_reg <= S_OUT;
                        else if (pred_reg ? (is_right && pl) : (!is_right && pr))
                        begin
                            node_reg  <= pred_reg ? node_reg - NW'(1) : node_reg + NW'(1);
                            state_reg <= S_DOWN;
                        end
                        else
                            node_reg <= {1'b0, node_reg[NW-1:1]};
                    end
                end
                S_DOWN:
                begin
                    if (!rd_ok_reg)
                        rd_ok_reg <= 1'b1;
                    else
                    begin
                        rd_ok_reg <= 1'b0;
                        if (!inner)
                        begin
                            cand_reg  <= node_reg[LB-1:0];
                            state_reg <= S_KREAD;
                        end
                        else if (pred_reg)
                            node_reg <= {node_reg[NW-2:0], nr};
                        else
                            node_reg <= {node_reg[NW-2:0], !nl};
                    end
                end
                S_KREAD: state_reg <= S_VWAIT;
                S_VWAIT: state_reg <= (op_reg == btps_pkg::OP_INS_PRUNE) ? S_VCMP : S_OUT;
                S_VCMP:
                begin
                    if ($signed(ram_rd) >= $signed(newv_reg))
                    begin
                        if (cnt_reg != CW'(btps_pkg::COUNT_MAX)) cnt_reg <= cnt_reg + CW'(1);
                        node_reg  <= {1'b1, cand_reg};
                        state_reg <= S_REM;
                    end
                    else
                    begin
                        node_reg  <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    obuf_reg.found         <= q_hit;
                    obuf_reg.found_key     <= q_hit ? btps_pkg::KEY_W'(cand_reg) : '0;
                    obuf_reg.found_value   <= q_hit ? widen(ram_rd) : '0;
                    obuf_reg.removed_count <= btps_pkg::KEY_W'(cnt_reg);
                    oval_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `CHK_IMPL(a_take_idle, clk, rst_n, q_take, state_reg == S_IDLE && !oval_reg)
    `CHK_IMPL(a_out_sets, clk, rst_n, state_reg == S_OUT, ##1 oval_reg)
    `CHK_IMPL(a_cmp_prune, clk, rst_n, state_reg == S_VCMP, op_reg == btps_pkg::OP_INS_PRUNE)
endmodule

// ----- rtl/core/bit_tree_predecessor_successor.sv -----
// A query climbs the tree and, if a neighbour exists, descends it; an insert with
// pruning adds a successor search, compare and removal per removed key. One item
// is worked at a time; each tree step is a node bit read, then a move. An item is
// taken only when the engine is idle and its last result is popped. After reset a
// clearing pass zeroes the node bits before the first item; up to two items queue.
// Depends on btps_pkg, btps_front, btps_engine.
module bit_tree_predecessor_successor #(
    parameter int LEAVES     = btps_pkg::LEAVES_DEF,
    parameter int VALUE_BITS = btps_pkg::VALUE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  btps_pkg::in_item_t  in_item,
    output logic                empty,
    input  logic                pop,
    output btps_pkg::out_item_t out_item
);
    logic               q_valid, q_take, q_noop;
    btps_pkg::in_item_t q_item;

    btps_front #(.LEAVES(LEAVES)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .q_valid(q_valid), .q_take(q_take), .q_item(q_item), .q_noop(q_noop)
    );

    btps_engine #(.LEAVES(LEAVES), .VALUE_BITS(VALUE_BITS)) u_engine (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
        .q_item(q_item), .q_noop(q_noop), .empty(empty), .pop(pop),
        .out_item(out_item)
    );
endmodule
